/* rtl/nlva_pkg.sv */
`default_nettype none
package nlva_pkg;

	localparam int MAX_EVENTS   = 256;
	localparam int VOICES       = 8;
	localparam int HELD_DEPTH   = 16;
	localparam int MAX_FIRE     = 32;
	localparam int RESULT_LIMIT = 48;

	localparam int EV_AW = $clog2(MAX_EVENTS);
	localparam int EV_CW = $clog2(MAX_EVENTS + 1);
	localparam int VIW   = (VOICES > 1) ? $clog2(VOICES) : 1;
	localparam int HIW   = $clog2(HELD_DEPTH);
	localparam int HCW   = $clog2(HELD_DEPTH + 1);
	localparam int FCW   = $clog2(MAX_FIRE + 1);
	localparam int RCW   = $clog2(RESULT_LIMIT + 1);

	typedef enum logic [3:0] {
		OP_KEY_ON      = 4'd0,
		OP_KEY_OFF     = 4'd1,
		OP_TICK        = 4'd2,
		OP_REC_START   = 4'd3,
		OP_REC_STOP    = 4'd4,
		OP_REC_ABORT   = 4'd5,
		OP_PLAY_START  = 4'd6,
		OP_PLAY_STOP   = 4'd7,
		OP_REWIND      = 4'd8,
		OP_CLEAR       = 4'd9,
		OP_RELEASE_ALL = 4'd10
	} op_t;

	typedef enum logic [4:0] {
		CMD_NONE,
		CMD_LATCH,
		CMD_KEY_ON,
		CMD_KEY_OFF,
		CMD_SND_OFF,
		CMD_TICK_ADV,
		CMD_FIRE,
		CMD_WRAP,
		CMD_REC_PRE,
		CMD_REC_GO,
		CMD_REC_STOP,
		CMD_REC_ABORT,
		CMD_PLAY_START,
		CMD_PLAY_STOP,
		CMD_REWIND,
		CMD_CLEAR,
		CMD_REL_VOICE,
		CMD_FLUSH
	} cmd_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_DISPATCH,
		ST_SND,
		ST_POST,
		ST_T_WAIT,
		ST_T_CHECK,
		ST_REL,
		ST_FLUSH
	} state_t;

	typedef struct packed {
		op_t  op;
		logic emit_ok;
		logic out_free;
		logic pend_v;
		logic due;
		logic fire_ok;
		logic wrap;
		logic snd_any;
		logic playing;
		logic ev_any;
		logic held_any;
		logic vlast;
	} status_t;

endpackage
`default_nettype wire

/* rtl/note_looper_voice_allocator_unit.sv */
`default_nettype none
// Channel   Direction  Handshake             Payload
// in        input      in_valid / in_ready    op[3:0], note[6:0]
// out       output     out_valid / out_ready  voice, voice_hit, gate, pitch, click, last
//
// One input transfer is taken only while the controller is idle. Key events and the simple
// transport ops pass through dispatch and flush; rec_start, rewind and clear also send one
// note-off per sounding note first, and release_all with held notes releases every voice.
// A tick advances the clocks and, when playing, fires the due events, rereading the event
// store after each since its read is registered; a wrap adds one note-off per sounding note.
// Reset clears all control state and the voice table; the event store and note lists
// are not cleared. A result waits in a pending register until the next one shows whether
// it is the last, so a stalled output transfer only pauses the work.
module note_looper_voice_allocator_unit (
	input  wire logic       clk,
	input  wire logic       arst_n,
	input  wire logic       in_valid,
	output logic            in_ready,
	input  wire logic [3:0] op,
	input  wire logic [6:0] note,
	output logic            out_valid,
	input  wire logic       out_ready,
	output logic [2:0]      voice,
	output logic            voice_hit,
	output logic            gate,
	output logic [6:0]      pitch,
	output logic            click,
	output logic            last
);

	// Command and status between the sequencer and the datapath.
	nlva_pkg::cmd_t    cmd;
	nlva_pkg::status_t st;

	nlva_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_ready (in_ready),
		.st       (st),
		.cmd      (cmd)
	);

	// The datapath holds the looper state, the event store, the voice table and the
	// output registers.
	nlva_dp u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd       (cmd),
		.st        (st),
		.op        (op),
		.note      (note),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.voice     (voice),
		.voice_hit (voice_hit),
		.gate      (gate),
		.pitch     (pitch),
		.click     (click),
		.last      (last)
	);

endmodule
`default_nettype wire

/* rtl/nlva_ctrl.sv */
`default_nettype none
module nlva_ctrl (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              in_valid,
	output logic                   in_ready,
	input  wire nlva_pkg::status_t st,
	output nlva_pkg::cmd_t         cmd
);

	nlva_pkg::state_t state_q, state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= nlva_pkg::ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d  = state_q;
		cmd      = nlva_pkg::CMD_NONE;
		in_ready = 1'b0;
		unique case (state_q)
			nlva_pkg::ST_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					cmd     = nlva_pkg::CMD_LATCH;
					state_d = nlva_pkg::ST_DISPATCH;
				end
			end
			nlva_pkg::ST_DISPATCH: begin
				state_d = nlva_pkg::ST_FLUSH;
				unique case (st.op)
					nlva_pkg::OP_KEY_ON: begin
						if (st.emit_ok) cmd = nlva_pkg::CMD_KEY_ON;
						else state_d = nlva_pkg::ST_DISPATCH;
					end
					nlva_pkg::OP_KEY_OFF: begin
						if (st.emit_ok) cmd = nlva_pkg::CMD_KEY_OFF;
						else state_d = nlva_pkg::ST_DISPATCH;
					end
					nlva_pkg::OP_TICK: begin
						cmd     = nlva_pkg::CMD_TICK_ADV;
						state_d = nlva_pkg::ST_T_WAIT;
					end
					nlva_pkg::OP_REC_START: begin
						cmd     = nlva_pkg::CMD_REC_PRE;
						state_d = nlva_pkg::ST_SND;
					end
					nlva_pkg::OP_REC_STOP:   cmd = nlva_pkg::CMD_REC_STOP;
					nlva_pkg::OP_REC_ABORT:  cmd = nlva_pkg::CMD_REC_ABORT;
					nlva_pkg::OP_PLAY_START: cmd = nlva_pkg::CMD_PLAY_START;
					nlva_pkg::OP_PLAY_STOP:  cmd = nlva_pkg::CMD_PLAY_STOP;
					nlva_pkg::OP_REWIND: begin
						cmd     = nlva_pkg::CMD_REWIND;
						state_d = nlva_pkg::ST_SND;
					end
					nlva_pkg::OP_CLEAR: state_d = nlva_pkg::ST_SND;
					nlva_pkg::OP_RELEASE_ALL: begin
						if (st.held_any) state_d = nlva_pkg::ST_REL;
					end
					default: state_d = nlva_pkg::ST_FLUSH;
				endcase
			end
			nlva_pkg::ST_SND: begin
				if (!st.snd_any) begin
					state_d = nlva_pkg::ST_POST;
				end else if (st.emit_ok) begin
					cmd = nlva_pkg::CMD_SND_OFF;
				end
			end
			nlva_pkg::ST_POST: begin
				state_d = nlva_pkg::ST_FLUSH;
				if (st.op == nlva_pkg::OP_REC_START) cmd = nlva_pkg::CMD_REC_GO;
				else if (st.op == nlva_pkg::OP_CLEAR) cmd = nlva_pkg::CMD_CLEAR;
			end
			nlva_pkg::ST_T_WAIT: begin
				if (st.playing && st.ev_any) state_d = nlva_pkg::ST_T_CHECK;
				else state_d = nlva_pkg::ST_FLUSH;
			end
			nlva_pkg::ST_T_CHECK: begin
				if (st.due && st.fire_ok) begin
					if (st.emit_ok) begin
						cmd     = nlva_pkg::CMD_FIRE;
						state_d = nlva_pkg::ST_T_WAIT;
					end
				end else if (st.wrap) begin
					cmd     = nlva_pkg::CMD_WRAP;
					state_d = nlva_pkg::ST_SND;
				end else begin
					state_d = nlva_pkg::ST_FLUSH;
				end
			end
			nlva_pkg::ST_REL: begin
				if (st.emit_ok) begin
					cmd = nlva_pkg::CMD_REL_VOICE;
					if (st.vlast) state_d = nlva_pkg::ST_FLUSH;
				end
			end
			nlva_pkg::ST_FLUSH: begin
				if (!st.pend_v) begin
					state_d = nlva_pkg::ST_IDLE;
				end else if (st.out_free) begin
					cmd     = nlva_pkg::CMD_FLUSH;
					state_d = nlva_pkg::ST_IDLE;
				end
			end
			default: state_d = nlva_pkg::ST_IDLE;
		endcase
	end

endmodule
`default_nettype wire

/* rtl/nlva_dp.sv */
`default_nettype none
module nlva_dp (
	input  wire logic            clk,
	input  wire logic            arst_n,
	input  wire nlva_pkg::cmd_t  cmd,
	output nlva_pkg::status_t    st,
	input  wire logic [3:0]      op,
	input  wire logic [6:0]      note,
	output logic                 out_valid,
	input  wire logic            out_ready,
	output logic [2:0]           voice,
	output logic                 voice_hit,
	output logic                 gate,
	output logic [6:0]           pitch,
	output logic                 click,
	output logic                 last
);

	typedef logic [nlva_pkg::HELD_DEPTH-1:0][6:0] list_t;

	// Returns {found, index} of the first live entry equal to the note.
	function automatic logic [nlva_pkg::HIW:0] find_note(
		input list_t                    l,
		input logic [nlva_pkg::HCW-1:0] cnt,
		input logic [6:0]               n
	);
		logic                    f;
		logic [nlva_pkg::HIW-1:0] k;
		f = 1'b0;
		k = '0;
		for (int i = nlva_pkg::HELD_DEPTH - 1; i >= 0; i--) begin
			if ((nlva_pkg::HCW'(i) < cnt) && (l[i] == n)) begin
				f = 1'b1;
				k = nlva_pkg::HIW'(i);
			end
		end
		return {f, k};
	endfunction

	function automatic list_t close_gap(input list_t l, input logic [nlva_pkg::HIW-1:0] k);
		list_t r;
		r = l;
		for (int i = 0; i < nlva_pkg::HELD_DEPTH - 1; i++) begin
			if (nlva_pkg::HIW'(i) >= k) r[i] = l[i+1];
		end
		return r;
	endfunction

	logic [3:0]                   op_q;
	logic [6:0]                   note_q;
	logic [nlva_pkg::RCW-1:0]     res_cnt_q;
	logic [nlva_pkg::FCW-1:0]     fired_q;
	logic [nlva_pkg::VIW-1:0]     vidx_q;
	logic [nlva_pkg::EV_CW-1:0]   ev_cnt_q;
	logic [nlva_pkg::EV_CW-1:0]   pos_q;
	logic [31:0]                  loop_q;
	logic [31:0]                  rec_clk_q;
	logic [31:0]                  play_clk_q;
	logic [31:0]                  last_time_q;
	logic                         rec_q;
	logic                         play_q;
	logic [nlva_pkg::HCW-1:0]     held_cnt_q;
	logic [nlva_pkg::HCW-1:0]     snd_cnt_q;
	list_t                        held_q;
	list_t                        snd_q;
	logic [nlva_pkg::VOICES-1:0]  busy_q;
	logic [nlva_pkg::VOICES-1:0][6:0] vpitch_q;

	logic [39:0] ev_mem [nlva_pkg::MAX_EVENTS];
	logic [39:0] rd_q;

	logic        out_v_q;
	logic [2:0]  out_voice_q;
	logic        out_hit_q, out_gate_q, out_click_q, out_last_q;
	logic [6:0]  out_pitch_q;
	logic        pend_v_q;
	logic [2:0]  pend_voice_q;
	logic        pend_hit_q, pend_gate_q, pend_click_q;
	logic [6:0]  pend_pitch_q;

	logic        rd_on;
	logic [6:0]  rd_note;
	logic [31:0] rd_time;
	assign rd_on   = rd_q[39];
	assign rd_note = rd_q[38:32];
	assign rd_time = rd_q[31:0];

	logic                     due, wrap, out_free;
	logic                     na, na_on, emit_cmd, emit_act, flush_act, rec_wr;
	logic [6:0]               na_note, snd_top;
	logic [nlva_pkg::HIW-1:0] snd_top_idx;
	logic [nlva_pkg::HIW:0]   held_find, snd_find;
	logic [nlva_pkg::VIW-1:0] free_idx, match_idx;
	logic                     match;
	logic [2:0]               new_voice;
	logic                     new_hit, new_gate, new_click;
	logic [6:0]               new_pitch;
	logic                     vlast;

	assign due = (pos_q < ev_cnt_q) && (play_clk_q >= rd_time);
	assign wrap = (loop_q != 32'd0) && (play_clk_q >= loop_q) && !due;
	assign out_free = !out_v_q || out_ready;
	assign vlast = (vidx_q == nlva_pkg::VIW'(nlva_pkg::VOICES - 1));
	assign snd_top_idx = nlva_pkg::HIW'(snd_cnt_q - 1'b1);
	assign snd_top = snd_q[snd_top_idx];

	always_comb begin
		na = (cmd == nlva_pkg::CMD_KEY_ON) || (cmd == nlva_pkg::CMD_KEY_OFF) ||
			(cmd == nlva_pkg::CMD_SND_OFF) || (cmd == nlva_pkg::CMD_FIRE);
		na_on = (cmd == nlva_pkg::CMD_KEY_ON) || ((cmd == nlva_pkg::CMD_FIRE) && rd_on);
		case (cmd)
			nlva_pkg::CMD_FIRE:    na_note = rd_note;
			nlva_pkg::CMD_SND_OFF: na_note = snd_top;
			default:               na_note = note_q;
		endcase
		emit_cmd  = na || (cmd == nlva_pkg::CMD_REL_VOICE);
		emit_act  = emit_cmd && (res_cnt_q < nlva_pkg::RCW'(nlva_pkg::RESULT_LIMIT));
		flush_act = (cmd == nlva_pkg::CMD_FLUSH);
		rec_wr    = na && rec_q && (ev_cnt_q < nlva_pkg::EV_CW'(nlva_pkg::MAX_EVENTS));
	end

	// First free voice and first busy voice holding the note.
	always_comb begin
		free_idx  = '0;
		match_idx = '0;
		match     = 1'b0;
		for (int i = nlva_pkg::VOICES - 1; i >= 0; i--) begin
			if (!busy_q[i]) free_idx = nlva_pkg::VIW'(i);
			if (busy_q[i] && (vpitch_q[i] == na_note)) begin
				match_idx = nlva_pkg::VIW'(i);
				match     = 1'b1;
			end
		end
	end

	assign held_find = find_note(held_q, held_cnt_q, na_note);
	assign snd_find  = find_note(snd_q, snd_cnt_q, rd_note);

	always_comb begin
		new_click = 1'b0;
		if (cmd == nlva_pkg::CMD_REL_VOICE) begin
			new_voice = 3'(vidx_q);
			new_hit   = 1'b1;
			new_gate  = 1'b0;
			new_pitch = vpitch_q[vidx_q];
		end else if (na_on) begin
			new_voice = 3'(free_idx);
			new_hit   = 1'b1;
			new_gate  = 1'b1;
			new_pitch = na_note;
			new_click = (cmd == nlva_pkg::CMD_FIRE);
		end else begin
			new_voice = match ? 3'(match_idx) : 3'd0;
			new_hit   = match;
			new_gate  = 1'b0;
			new_pitch = na_note;
		end
	end

	always_comb begin
		st.op       = nlva_pkg::op_t'(op_q);
		st.emit_ok  = !pend_v_q || out_free;
		st.out_free = out_free;
		st.pend_v   = pend_v_q;
		st.due      = due;
		st.fire_ok  = fired_q < nlva_pkg::FCW'(nlva_pkg::MAX_FIRE);
		st.wrap     = wrap;
		st.snd_any  = snd_cnt_q != '0;
		st.playing  = play_q;
		st.ev_any   = ev_cnt_q != '0;
		st.held_any = held_cnt_q != '0;
		st.vlast    = vlast;
	end

	always_ff @(posedge clk) begin
		if (rec_wr) ev_mem[ev_cnt_q[nlva_pkg::EV_AW-1:0]] <= {na_on, na_note, rec_clk_q};
		rd_q <= ev_mem[pos_q[nlva_pkg::EV_AW-1:0]];
	end

	// List contents and latched payload carry no reset.
	always_ff @(posedge clk) begin
		if (cmd == nlva_pkg::CMD_LATCH) begin
			note_q <= note;
		end
		if (rec_wr) last_time_q <= rec_clk_q;
		if (na && na_on) begin
			if (held_cnt_q < nlva_pkg::HCW'(nlva_pkg::HELD_DEPTH))
				held_q[held_cnt_q[nlva_pkg::HIW-1:0]] <= na_note;
		end else if (na && held_find[nlva_pkg::HIW]) begin
			held_q <= close_gap(held_q, held_find[nlva_pkg::HIW-1:0]);
		end
		if ((cmd == nlva_pkg::CMD_FIRE) && rd_on) begin
			if (snd_cnt_q < nlva_pkg::HCW'(nlva_pkg::HELD_DEPTH))
				snd_q[snd_cnt_q[nlva_pkg::HIW-1:0]] <= rd_note;
		end else if ((cmd == nlva_pkg::CMD_FIRE) && snd_find[nlva_pkg::HIW]) begin
			snd_q <= close_gap(snd_q, snd_find[nlva_pkg::HIW-1:0]);
		end
		if (emit_act) begin
			pend_voice_q <= new_voice;
			pend_hit_q   <= new_hit;
			pend_gate_q  <= new_gate;
			pend_pitch_q <= new_pitch;
			pend_click_q <= new_click;
		end
		if ((emit_act && pend_v_q) || flush_act) begin
			out_voice_q <= pend_voice_q;
			out_hit_q   <= pend_hit_q;
			out_gate_q  <= pend_gate_q;
			out_pitch_q <= pend_pitch_q;
			out_click_q <= pend_click_q;
			out_last_q  <= flush_act;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			op_q       <= '0;
			res_cnt_q  <= '0;
			fired_q    <= '0;
			vidx_q     <= '0;
			ev_cnt_q   <= '0;
			pos_q      <= '0;
			loop_q     <= '0;
			rec_clk_q  <= '0;
			play_clk_q <= '0;
			rec_q      <= 1'b0;
			play_q     <= 1'b0;
			held_cnt_q <= '0;
			snd_cnt_q  <= '0;
			busy_q     <= '0;
			vpitch_q   <= '0;
			out_v_q    <= 1'b0;
			pend_v_q   <= 1'b0;
		end else begin
			if (emit_act && pend_v_q) out_v_q <= 1'b1;
			else if (flush_act) out_v_q <= 1'b1;
			else if (out_ready) out_v_q <= 1'b0;
			if (emit_act) pend_v_q <= 1'b1;
			else if (flush_act) pend_v_q <= 1'b0;
			if (emit_act) res_cnt_q <= res_cnt_q + 1'b1;
			if (rec_wr) ev_cnt_q <= ev_cnt_q + 1'b1;

			if (na) begin
				if (na_on) begin
					if (held_cnt_q < nlva_pkg::HCW'(nlva_pkg::HELD_DEPTH))
						held_cnt_q <= held_cnt_q + 1'b1;
					busy_q[free_idx]   <= 1'b1;
					vpitch_q[free_idx] <= na_note;
				end else begin
					if (held_find[nlva_pkg::HIW]) held_cnt_q <= held_cnt_q - 1'b1;
					if (match) busy_q[match_idx] <= 1'b0;
				end
			end

			case (cmd) inside
				nlva_pkg::CMD_LATCH: begin
					op_q      <= op;
					res_cnt_q <= '0;
					vidx_q    <= '0;
				end
				nlva_pkg::CMD_SND_OFF: snd_cnt_q <= snd_cnt_q - 1'b1;
				nlva_pkg::CMD_TICK_ADV: begin
					if (rec_q) rec_clk_q <= rec_clk_q + 32'd1;
					if (play_q) play_clk_q <= play_clk_q + 32'd1;
					fired_q <= '0;
				end
				nlva_pkg::CMD_FIRE: begin
					pos_q   <= pos_q + 1'b1;
					fired_q <= fired_q + 1'b1;
					if (rd_on) begin
						if (snd_cnt_q < nlva_pkg::HCW'(nlva_pkg::HELD_DEPTH))
							snd_cnt_q <= snd_cnt_q + 1'b1;
					end else if (snd_find[nlva_pkg::HIW]) begin
						snd_cnt_q <= snd_cnt_q - 1'b1;
					end
				end
				nlva_pkg::CMD_WRAP, nlva_pkg::CMD_REWIND: begin
					play_clk_q <= '0;
					pos_q      <= '0;
				end
				nlva_pkg::CMD_REC_PRE: begin
					play_q <= 1'b0;
					rec_q  <= 1'b0;
				end
				nlva_pkg::CMD_REC_GO: begin
					ev_cnt_q  <= '0;
					loop_q    <= '0;
					pos_q     <= '0;
					rec_q     <= 1'b1;
					rec_clk_q <= '0;
				end
				nlva_pkg::CMD_CLEAR: begin
					ev_cnt_q <= '0;
					loop_q   <= '0;
					pos_q    <= '0;
				end
				nlva_pkg::CMD_REC_STOP: begin
					rec_q <= 1'b0;
					if (ev_cnt_q != '0) loop_q <= last_time_q + 32'd1;
				end
				nlva_pkg::CMD_REC_ABORT: rec_q <= 1'b0;
				nlva_pkg::CMD_PLAY_START: begin
					if (ev_cnt_q != '0) begin
						play_q     <= 1'b1;
						pos_q      <= '0;
						play_clk_q <= '0;
					end
				end
				nlva_pkg::CMD_PLAY_STOP: begin
					play_q <= 1'b0;
					pos_q  <= '0;
				end
				nlva_pkg::CMD_REL_VOICE: begin
					busy_q[vidx_q] <= 1'b0;
					vidx_q         <= vidx_q + 1'b1;
					if (vlast) held_cnt_q <= '0;
				end
				default: begin
				end
			endcase
		end
	end

	assign out_valid = out_v_q;
	assign voice     = out_voice_q;
	assign voice_hit = out_hit_q;
	assign gate      = out_gate_q;
	assign pitch     = out_pitch_q;
	assign click     = out_click_q;
	assign last      = out_last_q;

`ifndef SYNTHESIS
	a_res_limit: assert property (@(posedge clk) disable iff (!arst_n)
		res_cnt_q <= nlva_pkg::RCW'(nlva_pkg::RESULT_LIMIT))
		else $error("result count beyond limit");
	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		(emit_act && pend_v_q) |-> out_free)
		else $error("pending result pushed into a full output register");
	a_list_depth: assert property (@(posedge clk) disable iff (!arst_n)
		(held_cnt_q <= nlva_pkg::HCW'(nlva_pkg::HELD_DEPTH)) &&
		(snd_cnt_q <= nlva_pkg::HCW'(nlva_pkg::HELD_DEPTH)))
		else $error("note list count beyond depth");
	a_flush_empties: assert property (@(posedge clk) disable iff (!arst_n)
		flush_act |=> !pend_v_q && out_v_q && out_last_q)
		else $error("flush did not deliver the final result");
`endif

endmodule
`default_nettype wire
